// ----- design/chroma_denoise_authority_unit_macros.svh -----
// Assertion macros for the port checker of the chroma denoise authority unit.
// Depends on nothing; pulled in by `include where assertions are written.
`ifndef CHROMA_DENOISE_AUTHORITY_UNIT_MACROS_SVH
`define CHROMA_DENOISE_AUTHORITY_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is low
`define CDAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication, off while reset is low
`define CDAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- design/cdau_pkg.sv -----
// Package of the chroma denoise authority unit: widths, fixed-point constants, codes.
// Used by cdau_ramp, the top level and the port checker; depends on nothing.
`default_nettype none

package cdau_pkg;

    // Widths
    localparam int FW      = 32;             // UQ4.28 input field
    localparam int EW      = 35;             // scaled edge, UQ.28 with headroom
    localparam int TW      = 15;             // ramp position t
    localparam int WW      = 16;             // UQ1.15 weight
    localparam int AW      = 15;             // authority
    localparam int CW      = 19;             // edge coefficient, UQ.16
    localparam int CFG_IW  = 4;              // config register index
    localparam int NIN     = 9;              // input fields
    localparam int IN_DW   = NIN * FW;
    localparam int OUT_DW  = 48;             // 47 bits of fields padded to bytes
    localparam int A1W     = 20;
    localparam int A2W     = 24;
    localparam int A3W     = 25;
    localparam int NSTG    = 24;             // pipeline register stages
    localparam int ADLY    = 18;             // delay of the early authority product

    // Config register indexes
    localparam logic [CFG_IW-1:0] REG_STRENGTH = 4'd0;
    localparam logic [CFG_IW-1:0] REG_GUIDE    = 4'd1;

    // Reset values
    localparam logic [WW-1:0] STRENGTH_RST = 16'd24904;
    localparam logic [FW-1:0] GUIDE_RST    = 32'd4831838;

    // Edge coefficients, UQ.16
    localparam logic [CW-1:0] K_CHR_LO = 19'd147456;
    localparam logic [CW-1:0] K_CHR_HI = 19'd344064;
    localparam logic [CW-1:0] K_LUM_LO = 19'd45875;
    localparam logic [CW-1:0] K_LUM_HI = 19'd157286;
    localparam logic [CW-1:0] K_VAR_LO = 19'd29491;
    localparam logic [CW-1:0] K_VAR_HI = 19'd121242;

    // Fixed edges, UQ7.28
    localparam logic [EW-1:0] FLOOR_LUM_LO = 35'd1073742;
    localparam logic [EW-1:0] FLOOR_LUM_HI = 35'd3221225;
    localparam logic [EW-1:0] SAT_E0       = 35'd91268055;
    localparam logic [EW-1:0] SAT_E1       = 35'd209379656;
    localparam logic [EW-1:0] HI_E0        = 35'd187904819;
    localparam logic [EW-1:0] HI_E1        = 35'd289910292;

    // Protection slopes and limits, UQ1.15
    localparam logic [14:0]   SAT_SLOPE = 15'd22938;
    localparam logic [14:0]   HI_SLOPE  = 15'd25559;
    localparam logic [WW-1:0] ONE_Q15   = 16'd32768;
    localparam logic [AW-1:0] AUTH_MAX  = 15'd30802;

    // Ramp modes
    localparam logic [1:0] RM_ZERO = 2'd0;
    localparam logic [1:0] RM_ONE  = 2'd1;
    localparam logic [1:0] RM_DIV  = 2'd2;

endpackage

`default_nettype wire

// ----- design/cdau_ramp.sv -----
// Pipelined smoothstep ramp: setup, one restoring-division bit per stage, two multiply stages.
// Depends on cdau_pkg; 18 register stages, one item per enabled cycle.
`default_nettype none

module cdau_ramp (
    input  wire logic                   aclk,
    input  wire logic                   en,
    input  wire logic [cdau_pkg::EW-1:0] e0,
    input  wire logic [cdau_pkg::EW-1:0] e1,
    input  wire logic [cdau_pkg::FW-1:0] v,
    output logic      [cdau_pkg::WW-1:0] y
);

    localparam int EW = cdau_pkg::EW;
    localparam int TW = cdau_pkg::TW;

    logic [EW-1:0] rem_reg  [0:TW];
    logic [EW-1:0] den_reg  [0:TW];
    logic [TW-1:0] quo_reg  [0:TW];
    logic [1:0]    mode_reg [0:TW];

    logic [EW-1:0] v_ext;
    logic [1:0]    mode_next;
    logic [2*TW-1:0] tt_reg;
    logic [16:0]     w_reg;
    logic [1:0]      mode1_reg;
    logic [46:0]     prod;
    logic [47:0]     rnd;
    logic [cdau_pkg::WW-1:0] y_reg;

    assign v_ext = EW'(v);

    // Classify the item against its edges
    always_comb begin
        if (e1 <= e0) begin
            mode_next = cdau_pkg::RM_ZERO;
        end else if (v_ext <= e0) begin
            mode_next = cdau_pkg::RM_ZERO;
        end else if (v_ext >= e1) begin
            mode_next = cdau_pkg::RM_ONE;
        end else begin
            mode_next = cdau_pkg::RM_DIV;
        end
    end

    // Setup stage: offset and span
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= v_ext - e0;
            den_reg[0]  <= e1 - e0;
            quo_reg[0]  <= '0;
            mode_reg[0] <= mode_next;
        end
    end

    // One quotient bit per stage
    for (genvar i = 1; i <= TW; i++) begin : g_div
        logic [EW:0] sh;
        logic        ge;
        logic [EW:0] diff;
        assign sh   = {rem_reg[i-1], 1'b0};
        assign ge   = sh >= {1'b0, den_reg[i-1]};
        assign diff = sh - {1'b0, den_reg[i-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? diff[EW-1:0] : sh[EW-1:0];
                den_reg[i]  <= den_reg[i-1];
                quo_reg[i]  <= {quo_reg[i-1][TW-2:0], ge};
                mode_reg[i] <= mode_reg[i-1];
            end
        end
    end

    // First multiply: t squared and the cubic weight
    always_ff @(posedge aclk) begin
        if (en) begin
            tt_reg    <= quo_reg[TW] * quo_reg[TW];
            w_reg     <= 17'd98304 - {1'b0, quo_reg[TW], 1'b0};
            mode1_reg <= mode_reg[TW];
        end
    end

    assign prod = tt_reg * w_reg;
    assign rnd  = {1'b0, prod} + 48'd536870912;

    // Second multiply, round, select
    always_ff @(posedge aclk) begin
        if (en) begin
            case (mode1_reg)
                cdau_pkg::RM_ONE: y_reg <= cdau_pkg::ONE_Q15;
                cdau_pkg::RM_DIV: y_reg <= rnd[45:30];
                default:          y_reg <= '0;
            endcase
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ----- design/chroma_denoise_authority_unit.sv -----
// Chroma denoise authority: 24 register stages, then an output register with a skid stage.
// Throughput: one item per cycle while the skid stage is empty;
// the five ramp dividers resolve one quotient bit per stage.
// Reset (aresetn low, synchronous) empties the pipeline and skid stage and reloads
// strength and guide_noise_sigma; no item or config write is taken during reset.
// Depends on cdau_pkg and cdau_ramp.
`default_nettype none

module chroma_denoise_authority_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cdau_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [cdau_pkg::FW-1:0]       cfg_data,
    // input items
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, from bit 0 up, 32 bits each: local_chroma_variance, tile_chroma_variance,
    // chroma_gradient, luma_gradient, tile_sigma, flatness, noise_pressure, saturation,
    // luma_level
    input  wire logic [cdau_pkg::IN_DW-1:0]    s_tdata,
    // result items
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, from bit 0 up: detail_protection (16), stochastic_evidence (16),
    // correction_authority (15), one zero pad bit
    output logic      [cdau_pkg::OUT_DW-1:0]   m_tdata
);

    localparam int FW  = cdau_pkg::FW;
    localparam int EW  = cdau_pkg::EW;
    localparam int WW  = cdau_pkg::WW;
    localparam int AW  = cdau_pkg::AW;
    localparam int A1W = cdau_pkg::A1W;
    localparam int A2W = cdau_pkg::A2W;
    localparam int A3W = cdau_pkg::A3W;

    // Control
    logic run_reg;
    logic adv;
    logic [cdau_pkg::NSTG-1:0] vld_reg;

    // Config registers
    logic [WW-1:0] strength_reg;
    logic [FW-1:0] guide_reg;

    // Input field split
    logic [FW-1:0] f_lvar, f_tvar, f_cgrad, f_lgrad, f_tsig, f_flat, f_press, f_sat, f_luma;

    // Edge products
    logic [50:0] p_ce0, p_ce1, p_le0, p_le1, p_ve0, p_ve1;
    logic [47:0] p_a1;

    // Stage 1
    logic [EW-1:0] ce0_reg, ce1_reg, le0_reg, le1_reg, ve0_reg, ve1_reg;
    logic [FW-1:0] cgrad_reg, lgrad_reg, lvar_reg, sat_reg, luma_reg, flat_reg;
    logic [A1W-1:0] a1_reg;

    // Stage 2 and delay line
    logic [51:0]    p_a2;
    logic [A2W-1:0] a2_reg;
    logic [A2W-1:0] adly_reg [0:cdau_pkg::ADLY-1];

    // Ramp outputs
    logic [WW-1:0] r_chr, r_lum, r_var, r_sat, r_hi;

    // Stage 20
    logic [WW-1:0]  det20_reg, evs20_reg, satp20_reg, hip20_reg;
    logic [WW-1:0]  det_max;
    logic [31:0]    p_satp, p_hip;
    logic [WW:0]    satp_sub, hip_sub;

    // Stage 21
    logic [32:0]    p_evid;
    logic [WW-1:0]  det21_reg, evid21_reg, satp21_reg, hip21_reg;
    logic [A2W-1:0] a21_reg;

    // Stages 22 to 24
    logic [39:0]    p_a22;
    logic [40:0]    p_a23, p_a24;
    logic [A3W-1:0] a22_reg, a23_reg;
    logic [WW-1:0]  det22_reg, evid22_reg, satp22_reg, hip22_reg;
    logic [WW-1:0]  det23_reg, evid23_reg, hip23_reg;
    logic [WW-1:0]  det24_reg, evid24_reg;
    logic [AW-1:0]  auth24_reg;
    logic [25:0]    a24_full;

    // Output register and skid stage
    logic                        out_v_reg, out_v_next;
    logic                        skid_v_reg, skid_v_next;
    logic [cdau_pkg::OUT_DW-1:0] out_d_reg, out_d_next;
    logic [cdau_pkg::OUT_DW-1:0] skid_d_reg, skid_d_next;
    logic [cdau_pkg::OUT_DW-1:0] fin_d;

    // Handshake
    assign adv       = run_reg && !skid_v_reg;
    assign s_tready  = adv;
    assign cfg_ready = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    // Config writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= cdau_pkg::STRENGTH_RST;
            guide_reg    <= cdau_pkg::GUIDE_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == cdau_pkg::REG_STRENGTH) begin
                strength_reg <= cfg_data[WW-1:0];
            end else if (cfg_index == cdau_pkg::REG_GUIDE) begin
                guide_reg <= cfg_data;
            end
        end
    end

    // Valid bits advance with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[cdau_pkg::NSTG-2:0], s_tvalid};
        end
    end

    assign f_lvar  = s_tdata[0*FW +: FW];
    assign f_tvar  = s_tdata[1*FW +: FW];
    assign f_cgrad = s_tdata[2*FW +: FW];
    assign f_lgrad = s_tdata[3*FW +: FW];
    assign f_tsig  = s_tdata[4*FW +: FW];
    assign f_flat  = s_tdata[5*FW +: FW];
    assign f_press = s_tdata[6*FW +: FW];
    assign f_sat   = s_tdata[7*FW +: FW];
    assign f_luma  = s_tdata[8*FW +: FW];

    assign p_ce0 = cdau_pkg::K_CHR_LO * f_tsig;
    assign p_ce1 = cdau_pkg::K_CHR_HI * f_tsig;
    assign p_le0 = cdau_pkg::K_LUM_LO * guide_reg;
    assign p_le1 = cdau_pkg::K_LUM_HI * guide_reg;
    assign p_ve0 = cdau_pkg::K_VAR_LO * f_tvar;
    assign p_ve1 = cdau_pkg::K_VAR_HI * f_tvar;
    assign p_a1  = strength_reg * f_press;

    // Stage 1: scale edges, hold luma edges above their floors, start authority chain
    always_ff @(posedge aclk) begin
        if (adv) begin
            ce0_reg   <= p_ce0[50:16];
            ce1_reg   <= p_ce1[50:16];
            le0_reg   <= (p_le0[50:16] < cdau_pkg::FLOOR_LUM_LO) ?
                         cdau_pkg::FLOOR_LUM_LO : p_le0[50:16];
            le1_reg   <= (p_le1[50:16] < cdau_pkg::FLOOR_LUM_HI) ?
                         cdau_pkg::FLOOR_LUM_HI : p_le1[50:16];
            ve0_reg   <= p_ve0[50:16];
            ve1_reg   <= p_ve1[50:16];
            cgrad_reg <= f_cgrad;
            lgrad_reg <= f_lgrad;
            lvar_reg  <= f_lvar;
            sat_reg   <= f_sat;
            luma_reg  <= f_luma;
            flat_reg  <= f_flat;
            a1_reg    <= p_a1[47:28];
        end
    end

    // Stage 2: times flatness, then wait for the ramps
    assign p_a2 = a1_reg * flat_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a2_reg      <= p_a2[51:28];
            adly_reg[0] <= a2_reg;
            for (int i = 1; i < cdau_pkg::ADLY; i++) begin
                adly_reg[i] <= adly_reg[i-1];
            end
        end
    end

    // Five ramps in parallel
    cdau_ramp u_chr (.aclk(aclk), .en(adv), .e0(ce0_reg), .e1(ce1_reg), .v(cgrad_reg),
                     .y(r_chr));
    cdau_ramp u_lum (.aclk(aclk), .en(adv), .e0(le0_reg), .e1(le1_reg), .v(lgrad_reg),
                     .y(r_lum));
    cdau_ramp u_var (.aclk(aclk), .en(adv), .e0(ve0_reg), .e1(ve1_reg), .v(lvar_reg),
                     .y(r_var));
    cdau_ramp u_sat (.aclk(aclk), .en(adv), .e0(cdau_pkg::SAT_E0), .e1(cdau_pkg::SAT_E1),
                     .v(sat_reg), .y(r_sat));
    cdau_ramp u_hi  (.aclk(aclk), .en(adv), .e0(cdau_pkg::HI_E0), .e1(cdau_pkg::HI_E1),
                     .v(luma_reg), .y(r_hi));

    // Stage 20: detail and protections
    assign det_max  = (r_chr > r_lum) ? r_chr : r_lum;
    assign p_satp   = (cdau_pkg::SAT_SLOPE * r_sat) + 32'd16384;
    assign p_hip    = (cdau_pkg::HI_SLOPE * r_hi) + 32'd16384;
    assign satp_sub = {1'b0, cdau_pkg::ONE_Q15} - p_satp[31:15];
    assign hip_sub  = {1'b0, cdau_pkg::ONE_Q15} - p_hip[31:15];

    always_ff @(posedge aclk) begin
        if (adv) begin
            det20_reg  <= det_max;
            evs20_reg  <= r_var;
            satp20_reg <= satp_sub[WW-1:0];
            hip20_reg  <= hip_sub[WW-1:0];
        end
    end

    // Stage 21: evidence
    assign p_evid = (evs20_reg * (cdau_pkg::ONE_Q15 - det20_reg)) + 33'd16384;

    always_ff @(posedge aclk) begin
        if (adv) begin
            evid21_reg <= p_evid[30:15];
            det21_reg  <= det20_reg;
            satp21_reg <= satp20_reg;
            hip21_reg  <= hip20_reg;
            a21_reg    <= adly_reg[cdau_pkg::ADLY-1];
        end
    end

    // Stages 22 to 24: finish the authority chain and clamp
    assign p_a22    = a21_reg * evid21_reg;
    assign p_a23    = a22_reg * satp22_reg;
    assign p_a24    = a23_reg * hip23_reg;
    assign a24_full = p_a24[40:15];

    always_ff @(posedge aclk) begin
        if (adv) begin
            a22_reg    <= p_a22[39:15];
            det22_reg  <= det21_reg;
            evid22_reg <= evid21_reg;
            satp22_reg <= satp21_reg;
            hip22_reg  <= hip21_reg;

            a23_reg    <= p_a23[39:15];
            det23_reg  <= det22_reg;
            evid23_reg <= evid22_reg;
            hip23_reg  <= hip22_reg;

            auth24_reg <= (a24_full > 26'(cdau_pkg::AUTH_MAX)) ?
                          cdau_pkg::AUTH_MAX : a24_full[AW-1:0];
            det24_reg  <= det23_reg;
            evid24_reg <= evid23_reg;
        end
    end

    assign fin_d = {1'b0, auth24_reg, evid24_reg, det24_reg};

    // Output register with skid stage
    always_comb begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg) begin
            if (m_tready) begin
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end else if (adv && vld_reg[cdau_pkg::NSTG-1]) begin
            if (!out_v_reg || m_tready) begin
                out_v_next = 1'b1;
                out_d_next = fin_d;
            end else begin
                skid_v_next = 1'b1;
                skid_d_next = fin_d;
            end
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule

`default_nettype wire

// ----- design/cdau_check.sv -----
// Port checker for the chroma denoise authority unit, bound to the top level.
// Depends on cdau_pkg and chroma_denoise_authority_unit_macros.svh.
`default_nettype none

`include "chroma_denoise_authority_unit_macros.svh"

module cdau_check (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [cdau_pkg::OUT_DW-1:0] m_tdata
);

    logic [15:0] det_w;
    logic [15:0] evid_w;
    logic [14:0] auth_w;
    logic        pad_w;

    // Split the result fields
    assign det_w  = m_tdata[15:0];
    assign evid_w = m_tdata[31:16];
    assign auth_w = m_tdata[46:32];
    assign pad_w  = m_tdata[47];

    // A stalled item holds
    `CDAU_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Authority stays within its clamp and the pad bit is clear
    `CDAU_ASSERT_IMP(a_auth, aclk, aresetn, m_tvalid, (auth_w <= cdau_pkg::AUTH_MAX) && !pad_w)

    // Weights stay within one
    `CDAU_ASSERT_IMP(a_wgt, aclk, aresetn, m_tvalid, (det_w | evid_w) <= cdau_pkg::ONE_Q15)

    // Full detail protection leaves no evidence and no authority
    `CDAU_ASSERT_IMP(a_full, aclk, aresetn, m_tvalid && (det_w == cdau_pkg::ONE_Q15), !(|evid_w || |auth_w))

endmodule

bind chroma_denoise_authority_unit cdau_check u_cdau_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
